>>> sv/cdi_pkg.sv
// Shared types, widths and register codes for the corner distance interpolator.
package cdi_pkg;

   // Field widths
   localparam int HEIGHT_BITS = 24;
   localparam int FRAC_BITS   = 16;
   localparam int GRID_W      = 17;
   localparam int ALT_W       = 32;
   localparam int IDX_W       = 16;

   // Weight path: offsets and weights run up to 1.0 in Q1.FRAC_BITS
   localparam int WT_W        = FRAC_BITS + 1;
   localparam int SQ_W        = 2 * WT_W;
   localparam int SQRT_IN_W   = 2 * FRAC_BITS + 1;
   localparam logic [WT_W-1:0] ONE_Q = WT_W'(1) << FRAC_BITS;

   // Square root pipeline: one root bit per step
   localparam int SQRT_PER_STG = 3;
   localparam int SQRT_STG     = (SQRT_IN_W + 2 * SQRT_PER_STG - 1) / (2 * SQRT_PER_STG);
   localparam int SQRT_STEPS   = SQRT_PER_STG * SQRT_STG;
   localparam int SQRT_X_W     = 2 * SQRT_STEPS;
   localparam int ROOT_W       = SQRT_STEPS;
   localparam int REM_W        = SQRT_STEPS + 2;

   // Weighted sums
   localparam int PROD_W = WT_W + HEIGHT_BITS;
   localparam int NUM_W  = PROD_W + 2;
   localparam int DEN_W  = WT_W + 2;

   // Divider pipeline: one quotient bit per step
   localparam int DIV_PER_STG = 4;
   localparam int DIV_STG     = ALT_W / DIV_PER_STG;
   localparam int QSHIFT      = 8;

   // Register port
   localparam int ADDR_W = 4;
   localparam int DATA_W = 32;

   typedef enum logic [1:0] {
      REG_GRID_WIDTH  = 2'd0,
      REG_GRID_HEIGHT = 2'd1,
      REG_NO_DATA     = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic        [IDX_W-1:0]       col_index;
      logic        [IDX_W-1:0]       row_index;
      logic        [FRAC_BITS-1:0]   frac_col;
      logic        [FRAC_BITS-1:0]   frac_row;
      logic signed [HEIGHT_BITS-1:0] h_here;
      logic signed [HEIGHT_BITS-1:0] h_right;
      logic signed [HEIGHT_BITS-1:0] h_below;
      logic signed [HEIGHT_BITS-1:0] h_diag;
   } req_type;

   typedef struct packed {
      logic signed [ALT_W-1:0] altitude_q8;
      logic                    no_valid_sample;
   } rsp_type;

endpackage

>>> sv/dem_corner_distance_interpolator.sv
// Top level: four-corner inverse distance interpolation pipeline with register port.
//
//   port group  direction  handshake             word
//   req_*       in         req_valid/req_ready   req_type: cell, offsets, corner heights
//   rsp_*       out        rsp_valid/rsp_ready   rsp_type: altitude_q8, no_valid_sample
//   csr (APB)   in/out     psel/penable/pready   grid_width, grid_height, no_data_value
//
// One word per cycle sustained while the receiver keeps rsp_ready high; 19 register stages
// (input, squares, 6 root stages, products, sums, 8 divider stages, output).
// The root and divider pipelines set the depth.
// Each stage holds its word until the next stage frees, so bubbles close up under stall.
// Synchronous reset clears valid bits and loads the register defaults.
module dem_corner_distance_interpolator import cdi_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_type           rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready
);

   localparam int SQ0  = 2;
   localparam int PS   = SQ0 + SQRT_STG;
   localparam int SS   = PS + 1;
   localparam int DS   = SS + 1;
   localparam int OS   = DS + DIV_STG;
   localparam int NSTG = OS + 1;

   // Configuration registers
   logic [GRID_W-1:0]             grid_width_ff, grid_height_ff;
   logic signed [HEIGHT_BITS-1:0] no_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= GRID_W'(65536);
         grid_height_ff <= GRID_W'(65536);
         no_data_ff     <= {1'b1, {(HEIGHT_BITS-1){1'b0}}};
      end else if (psel && penable && pwrite) begin
         unique case (paddr[ADDR_W-1:2])
            REG_GRID_WIDTH:  grid_width_ff  <= pwdata[GRID_W-1:0];
            REG_GRID_HEIGHT: grid_height_ff <= pwdata[GRID_W-1:0];
            REG_NO_DATA:     no_data_ff     <= pwdata[HEIGHT_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[ADDR_W-1:2])
         REG_GRID_WIDTH:  prdata = DATA_W'(grid_width_ff);
         REG_GRID_HEIGHT: prdata = DATA_W'(grid_height_ff);
         REG_NO_DATA:     prdata = DATA_W'(no_data_ff);
         default:         prdata = '0;
      endcase
   end

   assign pready = 1'b1;

   // Stage flow control: a stage loads when empty or when its word moves on
   logic [NSTG-1:0] v_ff, en, v_src;

   always_comb begin
      en[NSTG-1] = !v_ff[NSTG-1] || rsp_ready;
      for (int k = NSTG - 2; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
   end

   assign v_src = {v_ff[NSTG-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= (en & v_src) | (~en & v_ff);
      end
   end

   assign req_ready = en[0];
   assign rsp_valid = v_ff[NSTG-1];

   // Stage 0: input word
   req_type in_ff;

   always_ff @(posedge clock) begin
      if (en[0]) begin
         in_ff <= req_data;
      end
   end

   // Stage 1: offset squares, corner masks, offset-binary heights
   logic [SQ_W-1:0]        sfc_ff, sec_ff, sfr_ff, ser_ff;
   logic [HEIGHT_BITS-1:0] hoff1_ff [4];
   logic [3:0]             use1_ff;

   logic [WT_W-1:0]               fc, fr, ec, er;
   logic signed [HEIGHT_BITS-1:0] h0 [4];
   logic                          has_right, has_below;
   logic [3:0]                    ok, use_v;

   always_comb begin
      fc = WT_W'(in_ff.frac_col);
      fr = WT_W'(in_ff.frac_row);
      ec = ONE_Q - fc;
      er = ONE_Q - fr;
      h0[0] = in_ff.h_here;
      h0[1] = in_ff.h_right;
      h0[2] = in_ff.h_below;
      h0[3] = in_ff.h_diag;
      has_right = (GRID_W'(in_ff.col_index) + GRID_W'(1)) < grid_width_ff;
      has_below = (GRID_W'(in_ff.row_index) + GRID_W'(1)) < grid_height_ff;
      ok = {has_right && has_below, has_below, has_right, 1'b1};
      for (int k = 0; k < 4; k++) begin
         use_v[k] = ok[k] && (h0[k] != no_data_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         sfc_ff  <= SQ_W'(fc) * SQ_W'(fc);
         sec_ff  <= SQ_W'(ec) * SQ_W'(ec);
         sfr_ff  <= SQ_W'(fr) * SQ_W'(fr);
         ser_ff  <= SQ_W'(er) * SQ_W'(er);
         use1_ff <= use_v;
         for (int k = 0; k < 4; k++) begin
            hoff1_ff[k] <= {~h0[k][HEIGHT_BITS-1], h0[k][HEIGHT_BITS-2:0]};
         end
      end
   end

   // Stages 2..: half squared distance per corner into the root pipelines
   logic [SQ_W:0]          dsum [4];
   logic [SQRT_IN_W-1:0]   half_s [4];
   logic [WT_W-1:0]        root [4];

   always_comb begin
      dsum[0] = (SQ_W + 1)'(sfc_ff) + (SQ_W + 1)'(sfr_ff);
      dsum[1] = (SQ_W + 1)'(sec_ff) + (SQ_W + 1)'(sfr_ff);
      dsum[2] = (SQ_W + 1)'(sfc_ff) + (SQ_W + 1)'(ser_ff);
      dsum[3] = (SQ_W + 1)'(sec_ff) + (SQ_W + 1)'(ser_ff);
      for (int k = 0; k < 4; k++) begin
         half_s[k] = dsum[k][SQRT_IN_W:1];
      end
   end

   for (genvar k = 0; k < 4; k++) begin : g_corner
      cdi_isqrt u_isqrt (
         .clock    (clock),
         .en       (en[SQ0 +: SQRT_STG]),
         .x_in     (half_s[k]),
         .root_out (root[k])
      );
   end

   // Heights and masks ride alongside the root stages
   logic [HEIGHT_BITS-1:0] hoff_ff [SQRT_STG][4];
   logic [3:0]             use_ff  [SQRT_STG];

   always_ff @(posedge clock) begin
      if (en[SQ0]) begin
         hoff_ff[0] <= hoff1_ff;
         use_ff[0]  <= use1_ff;
      end
      for (int j = 1; j < SQRT_STG; j++) begin
         if (en[SQ0 + j]) begin
            hoff_ff[j] <= hoff_ff[j-1];
            use_ff[j]  <= use_ff[j-1];
         end
      end
   end

   // Product stage: weight = 1 - root, masked weight times offset height
   logic [PROD_W-1:0] prod_ff [4];
   logic [WT_W-1:0]   wt_ff   [4];
   logic [WT_W-1:0]   wgt     [4];

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         wgt[k] = ONE_Q - root[k];
      end
   end

   always_ff @(posedge clock) begin
      if (en[PS]) begin
         for (int k = 0; k < 4; k++) begin
            if (use_ff[SQRT_STG-1][k]) begin
               prod_ff[k] <= PROD_W'(wgt[k]) * PROD_W'(hoff_ff[SQRT_STG-1][k]);
               wt_ff[k]   <= wgt[k];
            end else begin
               prod_ff[k] <= '0;
               wt_ff[k]   <= '0;
            end
         end
      end
   end

   // Sum stage
   logic [NUM_W-1:0] num_ff;
   logic [DEN_W-1:0] den_ff;

   always_ff @(posedge clock) begin
      if (en[SS]) begin
         num_ff <= NUM_W'(prod_ff[0]) + NUM_W'(prod_ff[1])
                 + NUM_W'(prod_ff[2]) + NUM_W'(prod_ff[3]);
         den_ff <= DEN_W'(wt_ff[0]) + DEN_W'(wt_ff[1])
                 + DEN_W'(wt_ff[2]) + DEN_W'(wt_ff[3]);
      end
   end

   // Divider stages; zero-weight flag travels alongside
   logic [ALT_W-1:0] quo;
   logic             zero_ff [DIV_STG];

   cdi_div u_div (
      .clock   (clock),
      .en      (en[DS +: DIV_STG]),
      .num_in  (num_ff),
      .den_in  (den_ff),
      .quo_out (quo)
   );

   always_ff @(posedge clock) begin
      if (en[DS]) begin
         zero_ff[0] <= (den_ff == '0);
      end
      for (int j = 1; j < DIV_STG; j++) begin
         if (en[DS + j]) begin
            zero_ff[j] <= zero_ff[j-1];
         end
      end
   end

   // Output stage: undo the height offset (quotient carries 2^31 extra)
   rsp_type rsp_ff;

   always_ff @(posedge clock) begin
      if (en[OS]) begin
         if (zero_ff[DIV_STG-1]) begin
            rsp_ff.altitude_q8     <= '0;
            rsp_ff.no_valid_sample <= 1'b1;
         end else begin
            rsp_ff.altitude_q8     <= {~quo[ALT_W-1], quo[ALT_W-2:0]};
            rsp_ff.no_valid_sample <= 1'b0;
         end
      end
   end

   assign rsp_data = rsp_ff;

endmodule

>>> sv/cdi_isqrt.sv
// Pipelined floor square root, a few root bits per stage.
module cdi_isqrt import cdi_pkg::*; (
   input  logic                 clock,
   input  logic [SQRT_STG-1:0]  en,
   input  logic [SQRT_IN_W-1:0] x_in,
   output logic [WT_W-1:0]      root_out
);

   logic [SQRT_X_W-1:0] x_ff    [SQRT_STG];
   logic [REM_W-1:0]    rem_ff  [SQRT_STG];
   logic [ROOT_W-1:0]   root_ff [SQRT_STG];

   for (genvar j = 0; j < SQRT_STG; j++) begin : g_stg
      logic [SQRT_X_W-1:0] x_prev, x_in_v;
      logic [REM_W-1:0]    rem_prev, rem_in_v;
      logic [ROOT_W-1:0]   root_prev, root_in_v;

      if (j == 0) begin : g_first
         assign x_prev    = SQRT_X_W'(x_in);
         assign rem_prev  = '0;
         assign root_prev = '0;
      end else begin : g_next
         assign x_prev    = x_ff[j-1];
         assign rem_prev  = rem_ff[j-1];
         assign root_prev = root_ff[j-1];
      end

      // restoring digit steps: bring down two operand bits, try root*4+1
      always_comb begin
         logic [SQRT_X_W-1:0] x;
         logic [REM_W-1:0]    rem;
         logic [ROOT_W-1:0]   root;
         logic [REM_W+1:0]    r2;
         logic [REM_W+1:0]    trial;
         x    = x_prev;
         rem  = rem_prev;
         root = root_prev;
         for (int i = 0; i < SQRT_PER_STG; i++) begin
            r2    = {rem, x[SQRT_X_W-1 -: 2]};
            x     = x << 2;
            trial = (REM_W + 2)'({root, 2'b01});
            if (r2 >= trial) begin
               r2   = r2 - trial;
               root = {root[ROOT_W-2:0], 1'b1};
            end else begin
               root = {root[ROOT_W-2:0], 1'b0};
            end
            rem = r2[REM_W-1:0];
         end
         x_in_v    = x;
         rem_in_v  = rem;
         root_in_v = root;
      end

      always_ff @(posedge clock) begin
         if (en[j]) begin
            x_ff[j]    <= x_in_v;
            rem_ff[j]  <= rem_in_v;
            root_ff[j] <= root_in_v;
         end
      end
   end

   assign root_out = root_ff[SQRT_STG-1][WT_W-1:0];

endmodule

>>> sv/cdi_div.sv
// Pipelined unsigned restoring divider, a few quotient bits per stage.
module cdi_div import cdi_pkg::*; (
   input  logic               clock,
   input  logic [DIV_STG-1:0] en,
   input  logic [NUM_W-1:0]   num_in,
   input  logic [DEN_W-1:0]   den_in,
   output logic [ALT_W-1:0]   quo_out
);

   // low word holds the dividend bits still to bring down, quotient bits shift in
   logic [DEN_W-1:0] rem_ff [DIV_STG];
   logic [ALT_W-1:0] low_ff [DIV_STG];
   logic [DEN_W-1:0] den_ff [DIV_STG];

   for (genvar j = 0; j < DIV_STG; j++) begin : g_stg
      logic [DEN_W-1:0] rem_prev, rem_in_v, den_prev;
      logic [ALT_W-1:0] low_prev, low_in_v;

      if (j == 0) begin : g_first
         // dividend is num_in scaled by 2^QSHIFT; its top bits start below den
         assign rem_prev = num_in[NUM_W-1 -: DEN_W];
         assign low_prev = ALT_W'({num_in[NUM_W-DEN_W-1:0], QSHIFT'(0)});
         assign den_prev = den_in;
      end else begin : g_next
         assign rem_prev = rem_ff[j-1];
         assign low_prev = low_ff[j-1];
         assign den_prev = den_ff[j-1];
      end

      always_comb begin
         logic [DEN_W-1:0] rem;
         logic [ALT_W-1:0] low;
         logic [DEN_W:0]   t;
         rem = rem_prev;
         low = low_prev;
         for (int i = 0; i < DIV_PER_STG; i++) begin
            t   = {rem, low[ALT_W-1]};
            low = low << 1;
            if (t >= {1'b0, den_prev}) begin
               t      = t - {1'b0, den_prev};
               low[0] = 1'b1;
            end
            rem = t[DEN_W-1:0];
         end
         rem_in_v = rem;
         low_in_v = low;
      end

      always_ff @(posedge clock) begin
         if (en[j]) begin
            rem_ff[j] <= rem_in_v;
            low_ff[j] <= low_in_v;
            den_ff[j] <= den_prev;
         end
      end
   end

   assign quo_out = low_ff[DIV_STG-1];

endmodule

>>> test/cdi_scoreboard.sv
// Altitude predictor and result scoreboard for the corner distance interpolator testbench.
`timescale 1ns / 100ps
import cdi_pkg::*;

class cdi_scoreboard;
   logic [16:0] grid_width;
   logic [16:0] grid_height;
   logic signed [HEIGHT_BITS-1:0] no_data_value;
   rsp_type pending_alt[$];
   int unsigned errors;

   function new();
      grid_width = 17'd65536;
      grid_height = 17'd65536;
      no_data_value = {1'b1, {(HEIGHT_BITS-1){1'b0}}};
      errors = 0;
   endfunction

   // Integer square root, rounding down
   static function longint unsigned root_floor(longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   static function longint corner_wt(longint unsigned dx, longint unsigned dy);
      return longint'(64'd65536 - root_floor((dx * dx + dy * dy) >> 1));
   endfunction

   // Work out the interpolated altitude for one accepted word
   function void note_req(req_type q);
      longint unsigned fc, fr, ec, er;
      longint w[4];
      longint h[4];
      bit ok[4];
      bit has_right, has_below;
      longint n, d, qt, rm, alt;
      rsp_type e;
      fc = q.frac_col;
      fr = q.frac_row;
      ec = 65536 - fc;
      er = 65536 - fr;
      has_right = (32'(q.col_index) + 1) < 32'(grid_width);
      has_below = (32'(q.row_index) + 1) < 32'(grid_height);
      w[0] = corner_wt(fc, fr);
      w[1] = corner_wt(ec, fr);
      w[2] = corner_wt(fc, er);
      w[3] = corner_wt(ec, er);
      h[0] = q.h_here;
      h[1] = q.h_right;
      h[2] = q.h_below;
      h[3] = q.h_diag;
      ok[0] = 1;
      ok[1] = has_right;
      ok[2] = has_below;
      ok[3] = has_right && has_below;
      n = 0;
      d = 0;
      for (int k = 0; k < 4; k++)
         if (ok[k] && h[k] != longint'(no_data_value)) begin
            n += w[k] * h[k];
            d += w[k];
         end
      if (d == 0) begin
         e.altitude_q8 = 0;
         e.no_valid_sample = 1;
      end else begin
         qt = n / d;
         rm = n - qt * d;
         if (rm < 0) begin
            qt -= 1;
            rm += d;
         end
         alt = qt * 256 + (rm * 256) / d;
         if (alt > 64'sd2147483647) alt = 64'sd2147483647;
         if (alt < -64'sd2147483648) alt = -64'sd2147483648;
         e.altitude_q8 = alt[31:0];
         e.no_valid_sample = 0;
      end
      pending_alt.insert(pending_alt.size(), e);
   endfunction

   function void check_rsp(rsp_type a);
      rsp_type e;
      if (pending_alt.size() == 0) begin
         $error("unexpected result word %h", a);
         errors++;
         return;
      end
      e = pending_alt.pop_front();
      if (a.altitude_q8 !== e.altitude_q8) begin
         $error("altitude_q8 expected %0d actual %0d", e.altitude_q8, a.altitude_q8);
         errors++;
      end
      if (a.no_valid_sample !== e.no_valid_sample) begin
         $error("no_valid_sample expected %0d actual %0d", e.no_valid_sample,
                a.no_valid_sample);
         errors++;
      end
   endfunction
endclass

>>> test/testbench.sv
// Top-level testbench: drives cells, registers and stalls into the interpolator and checks results.
`timescale 1ns / 100ps

module testbench import cdi_pkg::*; ();
   localparam int LATENCY = 19;
   localparam int IDLE_LIMIT = 2000;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 0;
   rsp_type rsp_data;
   logic psel = 0;
   logic penable = 0;
   logic pwrite = 0;
   logic [ADDR_W-1:0] paddr = '0;
   logic [DATA_W-1:0] pwdata = '0;
   logic [DATA_W-1:0] prdata;
   logic pready;

   cdi_scoreboard alt_board = new();
   int unsigned idle_cycles = 0;
   bit stall_mode = 0;

   dem_corner_distance_interpolator i_dut (.*);

   always #5 clock = ~clock;

   // Check results and count idle cycles
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) alt_board.check_rsp(rsp_data);
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAIL dem_corner_distance_interpolator");
         $finish;
      end
   end

   // Receiver stall pattern: phases of always-ready and random stalls
   always @(posedge clock) begin
      if ($urandom_range(0, 199) == 0) stall_mode <= ~stall_mode;
      if (!stall_mode) rsp_ready <= 1;
      else rsp_ready <= ($urandom_range(0, 3) != 0);
   end

   // Setup and access cycle, then an idle gap with psel low before the next transfer
   task automatic write_reg(reg_index_type idx, logic [31:0] val);
      psel <= 1;
      penable <= 0;
      pwrite <= 1;
      paddr <= ADDR_W'(4 * int'(idx));
      pwdata <= val;
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      psel <= 0;
      penable <= 0;
      pwrite <= 0;
      @(posedge clock);
      case (idx)
         REG_GRID_WIDTH: alt_board.grid_width = val[16:0];
         REG_GRID_HEIGHT: alt_board.grid_height = val[16:0];
         default: alt_board.no_data_value = val[HEIGHT_BITS-1:0];
      endcase
   endtask

   task automatic send_cell(req_type q);
      req_valid <= 1;
      req_data <= q;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      alt_board.note_req(q);
   endtask

   task automatic drain();
      while (alt_board.pending_alt.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   function automatic logic [23:0] rand_height(logic [23:0] nd);
      case ($urandom_range(0, 9))
         0: return nd;
         1: return 24'h7FFFFF;
         2: return 24'h800000;
         default: return 24'($urandom);
      endcase
   endfunction

   function automatic req_type rand_cell(logic [23:0] nd);
      req_type q;
      q.col_index = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(65530, 65535))
                                                : 16'($urandom);
      q.row_index = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 8))
                                                : 16'($urandom);
      q.frac_col = ($urandom_range(0, 7) == 0) ? 16'(($urandom_range(0, 1)) * 16'hFFFF)
                                               : 16'($urandom);
      q.frac_row = 16'($urandom);
      q.h_here = rand_height(nd);
      q.h_right = rand_height(nd);
      q.h_below = rand_height(nd);
      q.h_diag = rand_height(nd);
      return q;
   endfunction

   // Random burst phase under the current register setting
   task automatic random_phase(int count, logic [23:0] nd);
      int sent;
      sent = 0;
      while (sent < count) begin
         int burst;
         burst = $urandom_range(1, 20);
         for (int b = 0; b < burst && sent < count; b++) begin
            send_cell(rand_cell(nd));
            sent++;
         end
         if ($urandom_range(0, 2) != 0) begin
            req_valid <= 0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
      req_valid <= 0;
   endtask

   initial begin
      req_type q;
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: extremes, no-data, borders
      q = '{16'd0, 16'd0, 16'd0, 16'd0, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF};
      send_cell(q);
      q.frac_col = 16'hFFFF; q.frac_row = 16'hFFFF;
      q.h_here = 24'sh800001; q.h_right = 24'sh800001;
      q.h_below = 24'sh800001; q.h_diag = 24'sh800001;
      send_cell(q);
      q.h_here = 24'sh800000; q.h_right = 24'sh800000;
      q.h_below = 24'sh800000; q.h_diag = 24'sh800000;
      send_cell(q);
      q = '{16'hFFFF, 16'hFFFF, 16'h8000, 16'h8000, 24'sd100, 24'sd200, 24'sd300, 24'sd400};
      send_cell(q);
      q.col_index = 16'hFFFE; q.row_index = 16'hFFFE;
      send_cell(q);
      q.frac_col = 16'hFFFF; q.frac_row = 16'd0; q.h_here = 24'sh800000;
      send_cell(q);
      q = '{16'd5, 16'd7, 16'h0001, 16'hFFFF, -24'sd5, 24'sd3, -24'sd1, 24'sd0};
      send_cell(q);
      req_valid <= 0;
      drain();

      // Small grid: borders skip corners, zero-weight totals appear
      write_reg(REG_GRID_WIDTH, 32'd1);
      write_reg(REG_GRID_HEIGHT, 32'd1);
      write_reg(REG_NO_DATA, 32'd0);
      q = '{16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 24'sd0, 24'sd9, 24'sd9, 24'sd9};
      send_cell(q);
      q.h_here = 24'sd77;
      send_cell(q);
      random_phase(150, 24'd0);
      drain();

      write_reg(REG_GRID_WIDTH, 32'd0);
      write_reg(REG_GRID_HEIGHT, 32'd9);
      write_reg(REG_NO_DATA, 32'h007FFFFF);
      random_phase(150, 24'h7FFFFF);
      drain();

      write_reg(REG_GRID_WIDTH, 32'd65535);
      write_reg(REG_GRID_HEIGHT, 32'd65536);
      write_reg(REG_NO_DATA, 32'h00FFFFFF);
      random_phase(300, 24'hFFFFFF);
      drain();

      write_reg(REG_GRID_WIDTH, 32'h0001FFFF);
      write_reg(REG_GRID_HEIGHT, 32'h0001FFFF);
      write_reg(REG_NO_DATA, 32'h00800000);
      random_phase(550, 24'h800000);

      drain();
      if (alt_board.errors == 0 && alt_board.pending_alt.size() == 0)
         $display("PASS dem_corner_distance_interpolator");
      else
         $display("FAIL dem_corner_distance_interpolator");
      $finish;
   end
endmodule

>>> files.f
sv/cdi_pkg.sv
sv/cdi_isqrt.sv
sv/cdi_div.sv
sv/dem_corner_distance_interpolator.sv
test/cdi_scoreboard.sv
test/testbench.sv
